[rtl/sttl_pkg.sv]
// Shared types and constants for the sorted time table with nearest-key lookup.
// Depends on nothing; used by the interfaces, controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package sttl_pkg;

   localparam int KIND_W      = 2;
   localparam int EPOCH_W     = 48;
   localparam int PAYLOAD_W   = 64;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 7;

   // operation codes carried by an input item
   typedef enum logic [KIND_W-1:0] {
      KIND_INSERT = 2'd0,
      KIND_LOOKUP = 2'd1,
      KIND_CLEAR  = 2'd2
   } kind_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic       cap;           // capture the item, start a search over the table
      logic       clear;         // empty the table
      logic       rd_mid;        // read the key at the search midpoint
      logic       step;          // narrow the search window
      logic       rd_probe;      // read keys at the found position and the one below
      logic       set_sel;       // latch the nearest entry index
      logic       rd_sel;        // read the nearest entry
      logic       set_idx;       // start a shift at the top of the table
      logic       rd_shift;      // read the entry below the shift index
      logic       wr_shift;      // move that entry up one place
      logic       wr_req;        // write the item's key and payload at the found position
      logic       inc_fill;      // one more entry held
      logic       res_load;      // load the result registers
      status_type res_status;
      logic       res_replaced;
      logic       res_hit;       // result carries the entry just read
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      kind_type kind;
      logic     empty;
      logic     full;
      logic     search_done;
      logic     match;
      logic     shift_more;
   } stat_type;

endpackage

`default_nettype wire

[rtl/sttl_req_if.sv]
// Input channel: valid/ready handshake with the operation, key and payload of an item.
// Depends on sttl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sttl_req_if;

   logic                           valid;
   logic                           ready;
   logic [sttl_pkg::KIND_W-1:0]    kind;
   logic [sttl_pkg::EPOCH_W-1:0]   epoch;
   logic [sttl_pkg::PAYLOAD_W-1:0] payload;

   modport source (output valid, output kind, output epoch, output payload, input ready);
   modport sink   (input valid, input kind, input epoch, input payload, output ready);

endinterface

`default_nettype wire

[rtl/sttl_rsp_if.sv]
// Result channel: valid/ready handshake with the status, hit entry and entry count.
// Depends on sttl_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sttl_rsp_if;

   logic                             valid;
   logic                             ready;
   logic [sttl_pkg::STATUS_W-1:0]    status;
   logic                             replaced;
   logic [sttl_pkg::EPOCH_W-1:0]     hit_epoch;
   logic [sttl_pkg::PAYLOAD_W-1:0]   hit_payload;
   logic [sttl_pkg::COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, output status, output replaced, output hit_epoch,
                   output hit_payload, output entry_count, input ready);
   modport sink   (input valid, input status, input replaced, input hit_epoch,
                   input hit_payload, input entry_count, output ready);

endinterface

`default_nettype wire

[rtl/sttl_ctrl.sv]
// Controller state machine: sequences search, shift, write and fetch steps per item.
// Depends on sttl_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sttl_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   input  wire sttl_pkg::stat_type stat,
   output sttl_pkg::cmd_type       cmd
);

   import sttl_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_DISPATCH = 10'b00_0000_0010,
      S_SEARCH   = 10'b00_0000_0100,
      S_CMP      = 10'b00_0000_1000,
      S_DECIDE   = 10'b00_0001_0000,
      S_SHIFT_RD = 10'b00_0010_0000,
      S_SHIFT_WR = 10'b00_0100_0000,
      S_FETCH    = 10'b00_1000_0000,
      S_HIT      = 10'b01_0000_0000,
      S_RESP     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // handshake
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_status = STATUS_DONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            case (stat.kind)
               KIND_INSERT: state_in = S_SEARCH;
               KIND_LOOKUP: begin
                  if (stat.empty) begin
                     cmd.res_load   = 1'b1;
                     cmd.res_status = STATUS_EMPTY;
                     state_in       = S_RESP;
                  end else begin
                     state_in = S_SEARCH;
                  end
               end
               KIND_CLEAR: begin
                  cmd.clear    = 1'b1;
                  cmd.res_load = 1'b1;
                  state_in     = S_RESP;
               end
               default: begin
                  cmd.res_load = 1'b1;
                  state_in     = S_RESP;
               end
            endcase
         end
         S_SEARCH: begin
            if (stat.search_done) begin
               cmd.rd_probe = 1'b1;
               state_in     = S_DECIDE;
            end else begin
               cmd.rd_mid = 1'b1;
               state_in   = S_CMP;
            end
         end
         S_CMP: begin
            cmd.step = 1'b1;
            state_in = S_SEARCH;
         end
         S_DECIDE: begin
            if (stat.kind == KIND_LOOKUP) begin
               cmd.set_sel = 1'b1;
               state_in    = S_FETCH;
            end else if (stat.match) begin
               cmd.wr_req       = 1'b1;
               cmd.res_load     = 1'b1;
               cmd.res_replaced = 1'b1;
               state_in         = S_RESP;
            end else if (stat.full) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STATUS_FULL;
               state_in       = S_RESP;
            end else begin
               cmd.set_idx = 1'b1;
               state_in    = S_SHIFT_RD;
            end
         end
         S_SHIFT_RD: begin
            if (stat.shift_more) begin
               cmd.rd_shift = 1'b1;
               state_in     = S_SHIFT_WR;
            end else begin
               cmd.wr_req   = 1'b1;
               cmd.inc_fill = 1'b1;
               cmd.res_load = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_SHIFT_WR: begin
            cmd.wr_shift = 1'b1;
            state_in     = S_SHIFT_RD;
         end
         S_FETCH: begin
            cmd.rd_sel = 1'b1;
            state_in   = S_HIT;
         end
         S_HIT: begin
            cmd.res_load = 1'b1;
            cmd.res_hit  = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

[rtl/sttl_dp.sv]
// Datapath: key and payload memories, binary search window, shift index and result registers.
// Depends on sttl_pkg for field widths, codes and the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module sttl_dp #(
   parameter int DEPTH = 64
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire sttl_pkg::cmd_type                cmd,
   output sttl_pkg::stat_type                    stat,
   input  wire logic [sttl_pkg::KIND_W-1:0]      in_kind,
   input  wire logic [sttl_pkg::EPOCH_W-1:0]     in_epoch,
   input  wire logic [sttl_pkg::PAYLOAD_W-1:0]   in_payload,
   output logic      [sttl_pkg::STATUS_W-1:0]    out_status,
   output logic                                  out_replaced,
   output logic      [sttl_pkg::EPOCH_W-1:0]     out_hit_epoch,
   output logic      [sttl_pkg::PAYLOAD_W-1:0]   out_hit_payload,
   output logic      [sttl_pkg::COUNT_OUT_W-1:0] out_entry_count
);

   import sttl_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   // memories
   logic [EPOCH_W-1:0]   key_mem [DEPTH];
   logic [PAYLOAD_W-1:0] pay_mem [DEPTH];

   // captured item
   logic [KIND_W-1:0]    kind_ff;
   logic [EPOCH_W-1:0]   epoch_ff;
   logic [PAYLOAD_W-1:0] pay_ff;

   // search window, shift index, nearest index, entry count
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] hi_ff, hi_in;
   logic [CW-1:0] idx_ff;
   logic [IW-1:0] sel_ff;
   logic [CW-1:0] fill_ff;

   // registered read data
   logic [EPOCH_W-1:0]   key_a_ff, key_b_ff;
   logic [PAYLOAD_W-1:0] pay_a_ff;

   // result registers
   logic [STATUS_W-1:0]  status_ff;
   logic                 replaced_ff;
   logic [EPOCH_W-1:0]   hit_key_ff;
   logic [PAYLOAD_W-1:0] hit_pay_ff;

   logic [CW-1:0] mid;
   logic [CW-1:0] lo_dec;
   logic [CW-1:0] idx_dec;
   logic [CW-1:0] fill_dec;
   logic          match;

   assign mid      = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign lo_dec   = lo_ff - ONE_C;
   assign idx_dec  = idx_ff - ONE_C;
   assign fill_dec = fill_ff - ONE_C;
   assign match    = (lo_ff < fill_ff) && (key_a_ff == epoch_ff);

   // status to the controller
   assign stat.kind        = kind_type'(kind_ff);
   assign stat.empty       = (fill_ff == '0);
   assign stat.full        = (fill_ff == DEPTH_C);
   assign stat.search_done = (lo_ff >= hi_ff);
   assign stat.match       = match;
   assign stat.shift_more  = (idx_ff > lo_ff);

   // read port a address
   logic          rd_a_en;
   logic [IW-1:0] rd_a_addr;
   always_comb begin
      rd_a_en   = cmd.rd_mid | cmd.rd_probe | cmd.rd_sel | cmd.rd_shift;
      rd_a_addr = lo_ff[IW-1:0];
      if (cmd.rd_mid)        rd_a_addr = mid[IW-1:0];
      else if (cmd.rd_sel)   rd_a_addr = sel_ff;
      else if (cmd.rd_shift) rd_a_addr = idx_dec[IW-1:0];
   end

   // write port: shift moves an entry up, otherwise the item goes in at the found position
   logic                 wr_en;
   logic [IW-1:0]        wr_addr;
   logic [EPOCH_W-1:0]   wr_key;
   logic [PAYLOAD_W-1:0] wr_pay;
   assign wr_en   = cmd.wr_shift | cmd.wr_req;
   assign wr_addr = cmd.wr_shift ? idx_ff[IW-1:0] : lo_ff[IW-1:0];
   assign wr_key  = cmd.wr_shift ? key_a_ff : epoch_ff;
   assign wr_pay  = cmd.wr_shift ? pay_a_ff : pay_ff;

   // memory access
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         pay_mem[wr_addr] <= wr_pay;
      end
      if (rd_a_en) begin
         key_a_ff <= key_mem[rd_a_addr];
         pay_a_ff <= pay_mem[rd_a_addr];
      end
      if (cmd.rd_probe) key_b_ff <= key_mem[lo_dec[IW-1:0]];
   end

   // search window update
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.cap) begin
         lo_in = '0;
         hi_in = fill_ff;
      end else if (cmd.step) begin
         if (key_a_ff < epoch_ff) lo_in = mid + ONE_C;
         else                     hi_in = mid;
      end
   end

   // nearest entry: exact match, clamp at either end, or the nearer neighbor (later on a tie)
   logic [EPOCH_W-1:0] dist_up, dist_down;
   logic [CW-1:0]      sel_pick;
   always_comb begin
      dist_up   = key_a_ff - epoch_ff;
      dist_down = epoch_ff - key_b_ff;
      if (match)                  sel_pick = lo_ff;
      else if (lo_ff == '0)       sel_pick = '0;
      else if (lo_ff == fill_ff)  sel_pick = fill_dec;
      else if (dist_down < dist_up) sel_pick = lo_dec;
      else                        sel_pick = lo_ff;
   end

   // item capture and index registers
   always_ff @(posedge clock) begin
      if (cmd.cap) begin
         kind_ff  <= in_kind;
         epoch_ff <= in_epoch;
         pay_ff   <= in_payload;
      end
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.set_sel) sel_ff <= sel_pick[IW-1:0];
      if (cmd.set_idx)       idx_ff <= fill_ff;
      else if (cmd.wr_shift) idx_ff <= idx_dec;
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset)             fill_ff <= '0;
      else if (cmd.clear)    fill_ff <= '0;
      else if (cmd.inc_fill) fill_ff <= fill_ff + ONE_C;
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         status_ff   <= cmd.res_status;
         replaced_ff <= cmd.res_replaced;
         hit_key_ff  <= cmd.res_hit ? key_a_ff : '0;
         hit_pay_ff  <= cmd.res_hit ? pay_a_ff : '0;
      end
   end

   // result outputs, count carried as its low bits
   logic [CW+COUNT_OUT_W-1:0] count_wide;
   assign count_wide      = {{COUNT_OUT_W{1'b0}}, fill_ff};
   assign out_status      = status_ff;
   assign out_replaced    = replaced_ff;
   assign out_hit_epoch   = hit_key_ff;
   assign out_hit_payload = hit_pay_ff;
   assign out_entry_count = count_wide[COUNT_OUT_W-1:0];

   // search only narrows a non-empty window
   a_step_window: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (lo_ff < hi_ff))
      else $error("search step on an empty window");

   // a new entry is never added to a full table
   a_inc_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.inc_fill |-> (fill_ff < DEPTH_C))
      else $error("entry added to a full table");

   // shifts stay above the insert position and inside the table
   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_shift |-> ((idx_ff > lo_ff) && (idx_ff < DEPTH_C)))
      else $error("shift outside the table");

   // clear leaves the table empty
   a_clear_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (fill_ff == '0))
      else $error("table not empty after clear");

endmodule

`default_nettype wire

[rtl/sorted_time_table_nearest_lookup_top.sv]
// Top level of the sorted time table with nearest-key lookup.
// Depends on sttl_pkg, sttl_req_if, sttl_rsp_if, sttl_ctrl and sttl_dp.
//
//   channel   | direction | handshake     | carries
//   ----------+-----------+---------------+----------------------------------------------
//   req_chan  | in        | valid / ready | kind, epoch, payload
//   rsp_chan  | out       | valid / ready | status, replaced, hit_epoch, hit_payload,
//             |           |               | entry_count
//
// One item at a time; each item gives one result. With n entries held, a binary
// search makes at most s = ceil(log2(n+1)) probes, each a memory read, then a compare.
// A lookup then reads the found key and the one below it and fetches the nearer entry;
// an insert moves each entry above the found position up one place through the single
// memory write port, except when the key is already held or the table is full; clear, a
// lookup on an empty table and the unused kind go straight to the result.
// Reset is synchronous and empties the table at once; memory contents are not cleared.
// A result stalled on rsp_chan holds the block: the next item is taken after it leaves.
`timescale 1ns / 1ps
`default_nettype none

module sorted_time_table_nearest_lookup_top #(
   parameter int DEPTH = 64
) (
   input wire logic    clock,
   input wire logic    reset,
   sttl_req_if.sink    req_chan,
   sttl_rsp_if.source  rsp_chan
);

   import sttl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // controller
   sttl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   sttl_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_kind         (req_chan.kind),
      .in_epoch        (req_chan.epoch),
      .in_payload      (req_chan.payload),
      .out_status      (rsp_chan.status),
      .out_replaced    (rsp_chan.replaced),
      .out_hit_epoch   (rsp_chan.hit_epoch),
      .out_hit_payload (rsp_chan.hit_payload),
      .out_entry_count (rsp_chan.entry_count)
   );

endmodule

`default_nettype wire
